// ===== rtl/palette_tint_blend_defines.svh =====
// Assertion macros shared by the checker files of the palette tint block.
// Each macro expects a signal named clk, and all but PTB_ASSERT_RESET one named rst_n, in the scope where it is used.
`ifndef PALETTE_TINT_BLEND_DEFINES_SVH
`define PALETTE_TINT_BLEND_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define PTB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("palette_tint_blend: same-cycle check failed");

// Next-cycle implication, ignored while reset is held.
`define PTB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("palette_tint_blend: next-cycle check failed");

// Next-cycle implication that is also checked across reset.
`define PTB_ASSERT_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("palette_tint_blend: reset check failed");

`endif

// ===== rtl/ptb_pkg.sv =====
// Shared types, constants and arithmetic functions for the palette tint block.
// No dependencies; ptb_cfg, ptb_shift_stage, ptb_gamma and palette_tint_blend refer to it by scoped names.
package ptb_pkg;

  // Number of shift registers in the register map.
  localparam int NUM_SHIFT_REGS = 4;
  // Default number of shifts actually applied.
  localparam int NUM_SHIFTS_DEF = 4;
  // Gamma table depth, fixed by the 8-bit channel width.
  localparam int GAMMA_DEPTH = 256;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Lite mode scaling by reciprocal multiplication:
  // floor(p*333/1000) == (p * 22347297) >> 26 and floor(p*9/10) == (p * 58986) >> 16
  // for every 8-bit percent p.
  localparam logic [24:0] LITE_CONTENTS_MUL = 25'd22347297;
  localparam logic [15:0] LITE_OTHER_MUL    = 16'd58986;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SHIFT_CONTENTS = 3'd0,
    REG_SHIFT_DAMAGE   = 3'd1,
    REG_SHIFT_BONUS    = 3'd2,
    REG_SHIFT_POWERUP  = 3'd3,
    REG_BLEND_ENABLE   = 3'd4,
    REG_LITE_MODE      = 3'd5
  } cfg_reg_t;

  // Input command codes.
  localparam logic CMD_BLEND       = 1'b0;
  localparam logic CMD_GAMMA_WRITE = 1'b1;

  // One item as it travels down the pipeline.
  typedef struct packed {
    logic       command;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] gamma_index;
    logic [7:0] gamma_value;
  } item_t;

  // Effective parameters of one shift stage.
  typedef struct packed {
    logic [7:0] amount;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } shift_prm_t;

  // Percent after lite scaling; contents uses 0.333, the others 0.9.
  function automatic logic [7:0] lite_amount(input logic is_contents, input logic [7:0] pct);
    logic [32:0] prod_c;
    logic [23:0] prod_o;
    prod_c = {25'd0, pct} * {8'd0, LITE_CONTENTS_MUL};
    prod_o = {16'd0, pct} * {8'd0, LITE_OTHER_MUL};
    if (is_contents) begin
      return {1'b0, prod_c[32:26]};
    end
    return prod_o[23:16];
  endfunction

  // One channel step: c + floor(amount*(target-c)/256), saturated to 0..255.
  function automatic logic [7:0] shift_channel(input logic [7:0] c, input logic [7:0] target,
                                               input logic [7:0] amount);
    logic signed [8:0]  diff;
    logic signed [8:0]  amt;
    logic signed [17:0] prod;
    logic signed [17:0] delta;
    logic signed [17:0] sum;
    diff  = $signed({1'b0, target}) - $signed({1'b0, c});
    amt   = $signed({1'b0, amount});
    prod  = 18'(diff) * 18'(amt);
    delta = prod >>> 8;
    sum   = $signed({10'd0, c}) + delta;
    if (sum < 0) begin
      return 8'd0;
    end
    if (sum > 18'sd255) begin
      return 8'd255;
    end
    return sum[7:0];
  endfunction

endpackage

// ===== rtl/ptb_cfg.sv =====
// Configuration registers and the per-shift effective amounts.
// Depends on ptb_pkg for the register map, types and lite scaling.
module ptb_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ptb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ptb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output ptb_pkg::shift_prm_t               prm [ptb_pkg::NUM_SHIFT_REGS]
);

  logic [31:0] shift_r [ptb_pkg::NUM_SHIFT_REGS];
  logic        blend_r;
  logic        lite_r;
  logic [7:0]  amount_r   [ptb_pkg::NUM_SHIFT_REGS];
  logic [7:0]  amount_nxt [ptb_pkg::NUM_SHIFT_REGS];

  // Register writes; indexes beyond the map are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ptb_pkg::NUM_SHIFT_REGS; i++) begin
        shift_r[i] <= '0;
      end
      blend_r <= 1'b1;
      lite_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (ptb_pkg::cfg_reg_t'(cfg_index))
        ptb_pkg::REG_SHIFT_CONTENTS: shift_r[0] <= cfg_wdata;
        ptb_pkg::REG_SHIFT_DAMAGE:   shift_r[1] <= cfg_wdata;
        ptb_pkg::REG_SHIFT_BONUS:    shift_r[2] <= cfg_wdata;
        ptb_pkg::REG_SHIFT_POWERUP:  shift_r[3] <= cfg_wdata;
        ptb_pkg::REG_BLEND_ENABLE:   blend_r    <= cfg_wdata[0];
        ptb_pkg::REG_LITE_MODE:      lite_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Effective amount; a disabled blend turns every shift into a no-op.
  always_comb begin
    for (int i = 0; i < ptb_pkg::NUM_SHIFT_REGS; i++) begin
      if (!blend_r) begin
        amount_nxt[i] = 8'd0;
      end else if (lite_r) begin
        amount_nxt[i] = ptb_pkg::lite_amount(i == 0, shift_r[i][31:24]);
      end else begin
        amount_nxt[i] = shift_r[i][31:24];
      end
    end
  end

  // Amounts are registered so the reciprocal multiply stays off the datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ptb_pkg::NUM_SHIFT_REGS; i++) begin
        amount_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < ptb_pkg::NUM_SHIFT_REGS; i++) begin
        amount_r[i] <= amount_nxt[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < ptb_pkg::NUM_SHIFT_REGS; i++) begin
      prm[i].amount = amount_r[i];
      prm[i].red    = shift_r[i][23:16];
      prm[i].green  = shift_r[i][15:8];
      prm[i].blue   = shift_r[i][7:0];
    end
  end

endmodule

// ===== rtl/ptb_shift_stage.sv =====
// One pipeline stage that applies a single color shift to all three channels.
// Depends on ptb_pkg for the item and parameter types and the channel function.
module ptb_shift_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ptb_pkg::item_t      in_item,
  input  ptb_pkg::shift_prm_t prm,
  output logic                out_valid,
  input  logic                out_ready,
  output ptb_pkg::item_t      out_item
);

  logic           valid_r;
  ptb_pkg::item_t item_r;
  ptb_pkg::item_t item_nxt;

  // The stage takes a new item when empty or when its item moves on.
  assign in_ready = !valid_r || out_ready;

  always_comb begin
    item_nxt       = in_item;
    item_nxt.red   = ptb_pkg::shift_channel(in_item.red,   prm.red,   prm.amount);
    item_nxt.green = ptb_pkg::shift_channel(in_item.green, prm.green, prm.amount);
    item_nxt.blue  = ptb_pkg::shift_channel(in_item.blue,  prm.blue,  prm.amount);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

// ===== rtl/ptb_gamma.sv =====
// Gamma table stage: executes table writes and looks up the three channels.
// Depends on ptb_pkg; holds one table copy per channel so each has its own read port.
module ptb_gamma (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ptb_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_red,
  output logic [7:0]     out_green,
  output logic [7:0]     out_blue
);

  logic [7:0] mem_red   [ptb_pkg::GAMMA_DEPTH];
  logic [7:0] mem_green [ptb_pkg::GAMMA_DEPTH];
  logic [7:0] mem_blue  [ptb_pkg::GAMMA_DEPTH];
  logic       valid_r;
  logic [7:0] red_r;
  logic [7:0] green_r;
  logic [7:0] blue_r;
  logic       take;

  assign in_ready = !valid_r || out_ready;
  assign take     = in_valid && in_ready;

  // A table write transaction updates all three copies and yields no result.
  always_ff @(posedge clk) begin
    if (take && (in_item.command == ptb_pkg::CMD_GAMMA_WRITE)) begin
      mem_red[in_item.gamma_index]   <= in_item.gamma_value;
      mem_green[in_item.gamma_index] <= in_item.gamma_value;
      mem_blue[in_item.gamma_index]  <= in_item.gamma_value;
    end
  end

  // Registered lookups form the output register.
  always_ff @(posedge clk) begin
    if (take && (in_item.command == ptb_pkg::CMD_BLEND)) begin
      red_r   <= mem_red[in_item.red];
      green_r <= mem_green[in_item.green];
      blue_r  <= mem_blue[in_item.blue];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid && (in_item.command == ptb_pkg::CMD_BLEND);
    end
  end

  assign out_valid = valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

// ===== rtl/palette_tint_blend.sv =====
// Top level of the palette tint block: input register, shift stages, gamma stage.
// Depends on ptb_pkg, ptb_cfg, ptb_shift_stage and ptb_gamma.
//
//   Channel | Direction | Signals                             | Content
//   in      | slave     | in_tvalid/tready/tdata[39:0]/tuser  | command, color or table write
//   out     | master    | out_tvalid/tready/tdata[23:0]       | gamma-corrected color
//   cfg     | write     | cfg_we/cfg_index[2:0]/cfg_wdata[31:0] | shift and mode registers
//
// One transaction enters per cycle unless the output stalls; a color passes through
// one register for input capture, one per shift multiply, and one for the gamma read.
// A table write passes through the same stages and produces no output transaction.
// Reset is synchronous and clears only valid bits and configuration; the table is not cleared.
// Each stage holds its item while the stage after it is full and stalled, so
// empty stages still fill while the output waits.
module palette_tint_blend #(
  parameter int NUM_SHIFTS = ptb_pkg::NUM_SHIFTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: red_in[7:0], green_in[15:8], blue_in[23:16], gamma_index[31:24],
  // gamma_value[39:32]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [39:0]                     in_tdata,
  // in_tuser: command[0]
  input  logic [0:0]                      in_tuser,
  // out_tdata: red_out[7:0], green_out[15:8], blue_out[23:16]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata,
  input  logic                            cfg_we,
  input  logic [ptb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ptb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  ptb_pkg::shift_prm_t prm [ptb_pkg::NUM_SHIFT_REGS];

  logic           p_valid [NUM_SHIFTS+1];
  logic           p_ready [NUM_SHIFTS+1];
  ptb_pkg::item_t p_item  [NUM_SHIFTS+1];

  logic           in_valid_r;
  ptb_pkg::item_t in_item_r;
  logic [7:0]     red_o;
  logic [7:0]     green_o;
  logic [7:0]     blue_o;

  ptb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .prm       (prm)
  );

  // Input capture register.
  assign in_tready = !in_valid_r || p_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.command     <= in_tuser[0];
      in_item_r.red         <= in_tdata[7:0];
      in_item_r.green       <= in_tdata[15:8];
      in_item_r.blue        <= in_tdata[23:16];
      in_item_r.gamma_index <= in_tdata[31:24];
      in_item_r.gamma_value <= in_tdata[39:32];
    end
  end

  assign p_valid[0] = in_valid_r;
  assign p_item[0]  = in_item_r;

  // Shift chain in the fixed order contents, damage, bonus, powerup.
  for (genvar k = 0; k < NUM_SHIFTS; k++) begin : g_shift
    ptb_shift_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (p_valid[k]),
      .in_ready  (p_ready[k]),
      .in_item   (p_item[k]),
      .prm       (prm[k]),
      .out_valid (p_valid[k+1]),
      .out_ready (p_ready[k+1]),
      .out_item  (p_item[k+1])
    );
  end

  ptb_gamma u_gamma (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p_valid[NUM_SHIFTS]),
    .in_ready  (p_ready[NUM_SHIFTS]),
    .in_item   (p_item[NUM_SHIFTS]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_red   (red_o),
    .out_green (green_o),
    .out_blue  (blue_o)
  );

  assign out_tdata = {blue_o, green_o, red_o};

endmodule

// ===== rtl/ptb_checker.sv =====
// Port-level checks for the palette tint block, bound to the top level.
// Depends on the assertion macros in palette_tint_blend_defines.svh.
`include "palette_tint_blend_defines.svh"

module ptb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // A stalled result stays offered.
  `PTB_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)

  // A stalled result keeps its color.
  `PTB_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata))

  // When the output register is free, every stage drains and the input is open.
  `PTB_ASSERT_SAME(a_in_open, !out_tvalid || out_tready, in_tready)

  // Reset empties the output register.
  `PTB_ASSERT_RESET(a_rst_empty, !rst_n, !out_tvalid)

endmodule

bind palette_tint_blend ptb_checker u_ptb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
